FILE: rtl/vbas_pkg.sv
// vbas_pkg: types and codes for the valve and ballast actuator sequencer
// no dependencies; used by valve_ballast_actuator_sequencer
package vbas_pkg;

  // command codes carried by each request
  localparam logic [1:0] CMD_IDLE    = 2'd0;
  localparam logic [1:0] CMD_VENT    = 2'd1;
  localparam logic [1:0] CMD_BALLAST = 2'd2;

  // valve motor drive codes
  localparam logic [1:0] DRIVE_STOP  = 2'd0;
  localparam logic [1:0] DRIVE_OPEN  = 2'd1;
  localparam logic [1:0] DRIVE_CLOSE = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VALVE_OPEN_TIME  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALVE_CLOSE_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALVE_OPEN_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VALVE_CLOSE_SPD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BALLAST_SPEED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_INTERVAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_CURRENT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_TIMEOUT    = 3'd7;

  localparam int unsigned CFG_DATA_W = 32;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  command;
    logic [15:0] motor_current_ma;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  valve_position;
    logic [1:0]  valve_drive;
    logic [15:0] valve_speed;
    logic        valve_changed;
    logic        ballast_running;
    logic        ballast_direction;
    logic [15:0] ballast_speed;
    logic        ballast_changed;
  } out_item_t;

endpackage

FILE: rtl/valve_ballast_actuator_sequencer.sv
// valve_ballast_actuator_sequencer: valve phase machine and ballast motor control
// depends on vbas_pkg for the request/result structs and codes
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------
//  in      | request   | in_valid_i / in_stall_o | in_data_i  (in_item_t)
//  out     | result    | out_valid_o / out_stall_i| out_data_o (out_item_t)
//  cfg     | write     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// one request per clock sustained while no result is stalled; a request is taken into the
// input register, then the single-pass update writes its result into the result register,
// from which it leaves while out_stall_i is low
// rst_ni clears all sequencer state and loads the register defaults at once
// a held result stalls the input register only while it is full; an empty input
// register keeps taking requests, so one request can wait behind a stalled result
// cfg writes are always ready and take effect on the next clock
module valve_ballast_actuator_sequencer #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  vbas_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output vbas_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [vbas_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [vbas_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // compare width wide enough for both a time value and a 32-bit register
  localparam int unsigned CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  typedef enum logic [1:0] {
    PH_CLOSED  = 2'd0,
    PH_OPENING = 2'd1,
    PH_OPEN    = 2'd2,
    PH_CLOSING = 2'd3
  } valve_phase_e;

  // configuration registers
  logic [31:0] valve_open_time_q, valve_close_time_q;
  logic [15:0] valve_open_speed_q, valve_close_speed_q, ballast_speed_q;
  logic [31:0] reverse_interval_q;
  logic [15:0] stall_current_q;
  logic [31:0] stall_timeout_q;

  // input register
  logic               in_valid_q;
  vbas_pkg::in_item_t in_q;

  // sequencer state
  valve_phase_e         phase_q, phase_d;
  logic [TIME_BITS-1:0] valve_end_q, valve_end_d;
  logic                 motor_on_q, motor_on_d;
  logic                 motor_dir_q, motor_dir_d;
  logic [TIME_BITS-1:0] run_total_q, run_total_d;
  logic [TIME_BITS-1:0] seg_start_q, seg_start_d;
  logic [TIME_BITS-1:0] last_unstalled_q, last_unstalled_d;

  // result register
  logic                out_valid_q;
  vbas_pkg::out_item_t out_q, out_d;

  logic advance;  // result register can take a new result this cycle
  logic proc;     // the held request is turned into a result this cycle
  logic take_in;  // a request is taken into the input register

  assign advance     = !out_valid_q || !out_stall_i;
  assign proc        = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign take_in     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // single-pass update of valve and ballast state for the held request
  always_comb begin
    logic [TIME_BITS-1:0] now;
    logic                 want_valve, want_ballast;
    logic                 vchg, bchg;
    logic [TIME_BITS-1:0] run_elapsed;
    logic [TIME_BITS-1:0] stall_elapsed;

    now          = TIME_BITS'(in_q.now_ms);
    want_valve   = (in_q.command == vbas_pkg::CMD_VENT);
    want_ballast = (in_q.command == vbas_pkg::CMD_BALLAST);
    vchg         = 1'b0;
    bchg         = 1'b0;

    phase_d          = phase_q;
    valve_end_d      = valve_end_q;
    motor_on_d       = motor_on_q;
    motor_dir_d      = motor_dir_q;
    run_total_d      = run_total_q;
    seg_start_d      = seg_start_q;
    last_unstalled_d = last_unstalled_q;

    // valve: open request, close request, then drive timeout
    if (want_valve && (phase_q == PH_CLOSING || phase_q == PH_CLOSED)) begin
      phase_d     = PH_OPENING;
      valve_end_d = now + TIME_BITS'(valve_open_time_q);
      vchg        = 1'b1;
    end
    if (!want_valve && (phase_q == PH_OPENING || phase_q == PH_OPEN)) begin
      phase_d     = PH_CLOSING;
      valve_end_d = now + TIME_BITS'(valve_close_time_q);
      vchg        = 1'b1;
    end
    if ((phase_d == PH_OPENING || phase_d == PH_CLOSING) && (now > valve_end_d)) begin
      phase_d = (phase_d == PH_OPENING) ? PH_OPEN : PH_CLOSED;
      vchg    = 1'b1;
    end

    // ballast: start, stop
    if (want_ballast && !motor_on_q) begin
      seg_start_d = now;
      motor_on_d  = 1'b1;
      bchg        = 1'b1;
    end
    if (!want_ballast && motor_on_q) begin
      run_total_d = run_total_q + now - seg_start_q;
      motor_on_d  = 1'b0;
      bchg        = 1'b1;
    end

    // run-interval reversal
    run_elapsed = run_total_d + now - seg_start_d;
    if (motor_on_d && (CMP_W'(run_elapsed) > CMP_W'(reverse_interval_q))) begin
      run_total_d = '0;
      seg_start_d = now;
      motor_dir_d = !motor_dir_d;
      bchg        = 1'b1;
    end

    // stall tracking and stall reversal, may flip direction a second time
    if (in_q.motor_current_ma < stall_current_q) begin
      last_unstalled_d = now;
    end
    stall_elapsed = now - last_unstalled_d;
    if (CMP_W'(stall_elapsed) > CMP_W'(stall_timeout_q)) begin
      last_unstalled_d = now;
      run_total_d      = '0;
      seg_start_d      = now;
      motor_dir_d      = !motor_dir_d;
      bchg             = 1'b1;
    end

    out_d.valve_position = phase_d;
    case (phase_d)
      PH_OPENING: begin
        out_d.valve_drive = vbas_pkg::DRIVE_OPEN;
        out_d.valve_speed = valve_open_speed_q;
      end
      PH_CLOSING: begin
        out_d.valve_drive = vbas_pkg::DRIVE_CLOSE;
        out_d.valve_speed = valve_close_speed_q;
      end
      default: begin
        out_d.valve_drive = vbas_pkg::DRIVE_STOP;
        out_d.valve_speed = '0;
      end
    endcase
    out_d.valve_changed     = vchg;
    out_d.ballast_running   = motor_on_d;
    out_d.ballast_direction = motor_dir_d;
    out_d.ballast_speed     = motor_on_d ? ballast_speed_q : '0;
    out_d.ballast_changed   = bchg;
  end

  // input register payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q <= in_data_i;
    end
  end

  // control, configuration, sequencer state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valve_open_time_q   <= 32'd1000;
      valve_close_time_q  <= 32'd1000;
      valve_open_speed_q  <= '0;
      valve_close_speed_q <= '0;
      ballast_speed_q     <= '0;
      reverse_interval_q  <= 32'd10000;
      stall_current_q     <= 16'd1000;
      stall_timeout_q     <= 32'd1000;
      in_valid_q          <= 1'b0;
      phase_q             <= PH_CLOSED;
      valve_end_q         <= '0;
      motor_on_q          <= 1'b0;
      motor_dir_q         <= 1'b0;
      run_total_q         <= '0;
      seg_start_q         <= '0;
      last_unstalled_q    <= '0;
      out_valid_q         <= 1'b0;
      out_q               <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          vbas_pkg::REG_VALVE_OPEN_TIME:  valve_open_time_q   <= cfg_data_i;
          vbas_pkg::REG_VALVE_CLOSE_TIME: valve_close_time_q  <= cfg_data_i;
          vbas_pkg::REG_VALVE_OPEN_SPEED: valve_open_speed_q  <= cfg_data_i[15:0];
          vbas_pkg::REG_VALVE_CLOSE_SPD:  valve_close_speed_q <= cfg_data_i[15:0];
          vbas_pkg::REG_BALLAST_SPEED:    ballast_speed_q     <= cfg_data_i[15:0];
          vbas_pkg::REG_REVERSE_INTERVAL: reverse_interval_q  <= cfg_data_i;
          vbas_pkg::REG_STALL_CURRENT:    stall_current_q     <= cfg_data_i[15:0];
          vbas_pkg::REG_STALL_TIMEOUT:    stall_timeout_q     <= cfg_data_i;
          default: ;
        endcase
      end

      if (take_in) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end

      if (proc) begin
        phase_q          <= phase_d;
        valve_end_q      <= valve_end_d;
        motor_on_q       <= motor_on_d;
        motor_dir_q      <= motor_dir_d;
        run_total_q      <= run_total_d;
        seg_start_q      <= seg_start_d;
        last_unstalled_q <= last_unstalled_d;
        out_q            <= out_d;
      end

      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // input side only holds off while a request waits behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a held result");

  // sequencer state moves only when a request is turned into a result
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc |=> ($stable(phase_q) && $stable(motor_on_q) && $stable(motor_dir_q)))
    else $error("sequencer state changed without a request");

  // valve drive agrees with the reported position
  a_drive_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.valve_drive == vbas_pkg::DRIVE_STOP) ==
                     (out_data_o.valve_position == PH_CLOSED ||
                      out_data_o.valve_position == PH_OPEN)))
    else $error("valve drive does not match position");

  // a start or stop of the ballast motor is always flagged as a change
  a_run_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (motor_on_d != motor_on_q) |=> out_q.ballast_changed)
    else $error("ballast run state changed without change flag");

endmodule
